// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the header parser RTL.
// Included by files that carry concurrent checks; needs clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk, idle during reset
`define ETHIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true
`define ETHIP_NEVER(name, cond, msg) \
  `ETHIP_ASSERT(name, !(cond), msg)

`endif

// ===== rtl/core/ethip_pkg.sv =====
// Package for the Ethernet/IP/L4 header parser: constants, status codes,
// the op passed from classifier to capture stage, and the result record.
package ethip_pkg;

  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [3:0]  IHL_MASK     = 4'hF;

  localparam logic [6:0]  ETH_HDR_LEN  = 7'd14;
  localparam logic [6:0]  POS_MAX      = 7'd127;
  localparam logic [6:0]  V4_IHL_POS   = 7'd14;
  localparam logic [6:0]  V4_PROTO_POS = 7'd23;
  localparam logic [6:0]  V4_SA_FIRST  = 7'd26;
  localparam logic [6:0]  V4_SA_LAST   = 7'd29;
  localparam logic [6:0]  V4_DA_FIRST  = 7'd30;
  localparam logic [6:0]  V4_DA_LAST   = 7'd33;
  localparam logic [6:0]  V4_ADDR_END  = 7'd34;
  localparam logic [6:0]  V6_NH_POS    = 7'd20;
  localparam logic [6:0]  V6_SAH_FIRST = 7'd22;
  localparam logic [6:0]  V6_SAH_LAST  = 7'd29;
  localparam logic [6:0]  V6_SAL_FIRST = 7'd30;
  localparam logic [6:0]  V6_SAL_LAST  = 7'd37;
  localparam logic [6:0]  V6_DAH_FIRST = 7'd38;
  localparam logic [6:0]  V6_DAH_LAST  = 7'd45;
  localparam logic [6:0]  V6_DAL_FIRST = 7'd46;
  localparam logic [6:0]  V6_DAL_LAST  = 7'd53;
  localparam logic [6:0]  V6_ADDR_END  = 7'd54;
  localparam logic [6:0]  V6_L4_START  = 7'd54;
  localparam logic [5:0]  V6_HDR_BYTES = 6'd40;
  localparam logic [6:0]  PORT_BYTES   = 7'd4;

  localparam int QDEPTH = 2;
  localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_IP      = 2'd1,
    ST_IP_L4   = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  typedef struct packed {
    logic dmac;
    logic smac;
    logic etype;
    logic proto;
    logic sa_hi;
    logic sa_lo;
    logic da_hi;
    logic da_lo;
    logic sport;
    logic dport;
  } cap_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cap_t       cap;
    logic       v4;
    logic       v6;
    logic [5:0] hdr_bytes;
    status_t    status;
  } op_t;

  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  protocol;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [63:0] dst_ip_hi;
    logic [63:0] dst_ip_lo;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    status_t     status;
  } result_t;

endpackage

// ===== rtl/core/ethip_front.sv =====
// Classifier: tracks byte position, EtherType, IHL and protocol, and tags
// each byte with the fields it feeds; computes status on the last byte.
// Depends on ethip_pkg.
module ethip_front
  import ethip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       q_ready,
  output logic       q_valid,
  output op_t        q_op
);

  logic [6:0]  pos, pos_next;
  logic [15:0] etype, etype_next;
  logic [3:0]  ihl, ihl_next;
  logic [7:0]  proto, proto_next;
  logic        acc;
  logic        is_v4, is_v6, v4n, v6n, l4n;
  logic        in_l3;
  logic [6:0]  l4_start, port_end, addr_end;
  logic [5:0]  hdr;
  cap_t        cap;
  status_t     status;

  assign acc     = in_valid && q_ready;
  assign q_valid = in_valid;
  assign is_v4   = (etype == ETYPE_IPV4);
  assign is_v6   = (etype == ETYPE_IPV6);

  always_comb begin
    cap        = '0;
    etype_next = etype;
    ihl_next   = ihl;
    proto_next = proto;
    in_l3      = 1'b0;
    l4_start   = V6_L4_START;
    if (pos < 7'd6) begin
      cap.dmac = 1'b1;
    end else if (pos < 7'd12) begin
      cap.smac = 1'b1;
    end else if (pos < ETH_HDR_LEN) begin
      cap.etype  = 1'b1;
      etype_next = {etype[7:0], in_data};
    end else if (is_v4) begin
      in_l3 = 1'b1;
      if (pos == V4_IHL_POS) ihl_next = in_data[3:0] & IHL_MASK;
      if (pos == V4_PROTO_POS) begin
        cap.proto  = 1'b1;
        proto_next = in_data;
      end
      cap.sa_lo = (pos >= V4_SA_FIRST) && (pos <= V4_SA_LAST);
      cap.da_lo = (pos >= V4_DA_FIRST) && (pos <= V4_DA_LAST);
      l4_start  = ETH_HDR_LEN + {1'b0, ihl_next, 2'b00};
    end else if (is_v6) begin
      in_l3 = 1'b1;
      if (pos == V6_NH_POS) begin
        cap.proto  = 1'b1;
        proto_next = in_data;
      end
      cap.sa_hi = (pos >= V6_SAH_FIRST) && (pos <= V6_SAH_LAST);
      cap.sa_lo = (pos >= V6_SAL_FIRST) && (pos <= V6_SAL_LAST);
      cap.da_hi = (pos >= V6_DAH_FIRST) && (pos <= V6_DAH_LAST);
      cap.da_lo = (pos >= V6_DAL_FIRST) && (pos <= V6_DAL_LAST);
    end
    if (in_l3) begin
      if ((pos >= l4_start) && (pos < l4_start + 7'd2)) begin
        cap.sport = 1'b1;
      end else if ((pos >= l4_start + 7'd2) && (pos < l4_start + PORT_BYTES)) begin
        cap.dport = 1'b1;
      end
    end

    pos_next = (pos == POS_MAX) ? POS_MAX : pos + 7'd1;

    // end-of-frame classification uses the values after this byte
    v4n      = (etype_next == ETYPE_IPV4);
    v6n      = (etype_next == ETYPE_IPV6);
    l4n      = (v4n || v6n) && ((proto_next == PROTO_TCP) || (proto_next == PROTO_UDP));
    hdr      = v4n ? {ihl_next, 2'b00} : (v6n ? V6_HDR_BYTES : 6'd0);
    addr_end = v4n ? V4_ADDR_END : V6_ADDR_END;
    port_end = ETH_HDR_LEN + {1'b0, hdr} + PORT_BYTES;
    priority if (pos_next < ETH_HDR_LEN) status = ST_TRUNC;
    else if (!(v4n || v6n))              status = ST_UNKNOWN;
    else if (pos_next < addr_end)        status = ST_TRUNC;
    else if (!l4n)                       status = ST_IP;
    else if (pos_next < port_end)        status = ST_TRUNC;
    else                                 status = ST_IP_L4;

    q_op.data      = in_data;
    q_op.last      = in_last;
    q_op.cap       = cap;
    q_op.v4        = v4n;
    q_op.v6        = v6n;
    q_op.hdr_bytes = hdr;
    q_op.status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      etype <= '0;
      ihl   <= '0;
      proto <= '0;
    end else if (acc) begin
      if (in_last) begin
        pos   <= '0;
        etype <= '0;
        ihl   <= '0;
        proto <= '0;
      end else begin
        pos   <= pos_next;
        etype <= etype_next;
        ihl   <= ihl_next;
        proto <= proto_next;
      end
    end
  end

`include "assert_macros.svh"
  `ETHIP_ASSERT(a_frame_restart, (acc && in_last) |=> (pos == '0), "position not cleared")
  `ETHIP_NEVER(a_port_overlap, (q_valid && cap.sport && cap.dport), "both port fields tagged")

endmodule

// ===== rtl/core/ethip_fifo.sv =====
// Short op queue between classifier and capture stage.
// Depends on ethip_pkg.
module ethip_fifo
  import ethip_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

  op_t            mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           push, pop;

  assign in_ready  = (count != QCW'(QDEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`include "assert_macros.svh"
  `ETHIP_ASSERT(a_count_bound, (count <= QCW'(QDEPTH)), "queue count over depth")

endmodule

// ===== rtl/core/ethip_back.sv =====
// Capture stage: shifts tagged bytes into the held fields and loads the
// output register on the last byte of a frame. Depends on ethip_pkg.
module ethip_back
  import ethip_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    op_valid,
  output logic    op_ready,
  input  op_t     op,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic [47:0] dmac, dmac_n, smac, smac_n;
  logic [15:0] etype, etype_n;
  logic [7:0]  proto, proto_n;
  logic [63:0] sa_hi, sa_hi_n, sa_lo, sa_lo_n, da_hi, da_hi_n, da_lo, da_lo_n;
  logic [15:0] sport, sport_n, dport, dport_n;
  logic        pop, ip, l4ok;
  result_t     res_n;

  // only a last byte needs the output register free
  assign op_ready = !res_valid || res_ready || !op.last;
  assign pop      = op_valid && op_ready;

  always_comb begin
    dmac_n  = op.cap.dmac  ? {dmac[39:0], op.data}  : dmac;
    smac_n  = op.cap.smac  ? {smac[39:0], op.data}  : smac;
    etype_n = op.cap.etype ? {etype[7:0], op.data}  : etype;
    proto_n = op.cap.proto ? op.data                : proto;
    sa_hi_n = op.cap.sa_hi ? {sa_hi[55:0], op.data} : sa_hi;
    sa_lo_n = op.cap.sa_lo ? {sa_lo[55:0], op.data} : sa_lo;
    da_hi_n = op.cap.da_hi ? {da_hi[55:0], op.data} : da_hi;
    da_lo_n = op.cap.da_lo ? {da_lo[55:0], op.data} : da_lo;
    sport_n = op.cap.sport ? {sport[7:0], op.data}  : sport;
    dport_n = op.cap.dport ? {dport[7:0], op.data}  : dport;

    ip   = op.v4 || op.v6;
    l4ok = (op.status == ST_IP_L4);
    res_n.dst_mac         = dmac_n;
    res_n.src_mac         = smac_n;
    res_n.ether_type      = etype_n;
    res_n.ip_header_bytes = op.hdr_bytes;
    res_n.protocol        = ip ? proto_n : '0;
    res_n.src_ip_hi       = op.v6 ? sa_hi_n : '0;
    res_n.src_ip_lo       = ip ? sa_lo_n : '0;
    res_n.dst_ip_hi       = op.v6 ? da_hi_n : '0;
    res_n.dst_ip_lo       = ip ? da_lo_n : '0;
    res_n.l4_sport        = l4ok ? sport_n : '0;
    res_n.l4_dport        = l4ok ? dport_n : '0;
    res_n.status          = op.status;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && op.last)) begin
      dmac  <= '0;
      smac  <= '0;
      etype <= '0;
      proto <= '0;
      sa_hi <= '0;
      sa_lo <= '0;
      da_hi <= '0;
      da_lo <= '0;
      sport <= '0;
      dport <= '0;
    end else if (pop) begin
      dmac  <= dmac_n;
      smac  <= smac_n;
      etype <= etype_n;
      proto <= proto_n;
      sa_hi <= sa_hi_n;
      sa_lo <= sa_lo_n;
      da_hi <= da_hi_n;
      da_lo <= da_lo_n;
      sport <= sport_n;
      dport <= dport_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && op.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && op.last) res <= res_n;
  end

`include "assert_macros.svh"
  `ETHIP_ASSERT(a_res_source, $rose(res_valid) |-> $past(pop && op.last), "result without last byte")

endmodule

// ===== rtl/core/ethernet_ip_l4_header_parser.sv =====
// Top level of the Ethernet/IPv4/IPv6/TCP-UDP header parser.
// Depends on ethip_pkg, ethip_front, ethip_fifo, ethip_back.
//
//  channel  dir  tdata                   tuser    tlast
//  s_*      in   data_byte (8)           -        last_byte
//  m_*      out  header fields (416)     status   -
//
// One byte per cycle while s_tready is high. The classifier tags each byte as
// it is accepted; the capture stage, behind a two-entry op queue, takes one
// byte per cycle unless a last byte waits for the registered m_tvalid to clear.
// Reset clears position, held fields, queue and output valid; no clearing pass.
// While a result is not taken, bytes keep flowing until the next last byte reaches
// the capture stage; the queue then fills and s_tready drops.
module ethernet_ip_l4_header_parser
  import ethip_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dst_mac[47:0] src_mac[95:48] ether_type[111:96] ip_header_bytes[117:112]
  // protocol[125:118] src_ip_hi[189:126] src_ip_lo[253:190] dst_ip_hi[317:254]
  // dst_ip_lo[381:318] l4_sport[397:382] l4_dport[413:398] zero[415:414]
  output logic [415:0] m_tdata,
  output logic [1:0]   m_tuser    // [1:0] status
);

  logic    f_valid, f_ready, b_valid, b_ready;
  op_t     f_op, b_op;
  result_t res;

  ethip_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .q_ready  (f_ready),
    .q_valid  (f_valid),
    .q_op     (f_op)
  );

  ethip_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_op     (f_op),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_op    (b_op)
  );

  ethip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (b_valid),
    .op_ready  (b_ready),
    .op        (b_op),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign s_tready = f_ready;
  assign m_tdata  = {2'b00, res.l4_dport, res.l4_sport, res.dst_ip_lo, res.dst_ip_hi,
                     res.src_ip_lo, res.src_ip_hi, res.protocol, res.ip_header_bytes,
                     res.ether_type, res.src_mac, res.dst_mac};
  assign m_tuser  = res.status;

endmodule
